@@ hdl/tgi_pkg.sv @@
// Shared types, constants and the per-axis cell lookup for the trilinear grid interpolator.
// Used by every module under hdl except tgi_ram; depends on nothing else.
`default_nettype none

package tgi_pkg;

  localparam int GRID_X      = 32;
  localparam int GRID_Y      = 32;
  localparam int GRID_Z      = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = 32768;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GRID_TOTAL  = GRID_X * GRID_Y * GRID_Z;
  localparam int GRID_MAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GRID_MAX    = (GRID_MAX_XY > GRID_Z) ? GRID_MAX_XY : GRID_Z;
  localparam int IDX_W       = $clog2(GRID_MAX);

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int INV_W   = 24;
  localparam int PROD_W  = DIFF_W + INV_W + 1;
  localparam int FRAC_W  = 32;
  localparam int FL_W    = PROD_W - FRAC_W;
  localparam int W_W     = 16;
  localparam int E_W     = SAMPLE_BITS + W_W;
  localparam int OUT_W   = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd5;

  localparam logic [INV_W-1:0] INV_SPACING_RESET = 24'h010000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_RES_Z,
    ST_CHECK,
    ST_FETCH,
    ST_BLEND,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic                       command;
    logic [14:0]                sample_index;
    logic signed [15:0]         sample_value;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] interpolated_value;
    logic                    outside_grid;
  } out_item_t;

  typedef struct packed {
    logic       wr_en;
    logic       point_load;
    logic       mul_en;
    axis_sel_t  mul_axis;
    logic       res_en;
    axis_sel_t  res_axis;
    logic       rd_en;
    logic [2:0] corner;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic outside;
    logic blend_done;
  } dp_status_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [W_W-1:0]   w;
    logic             outside;
  } axis_res_t;

  // Split a Q32 grid coordinate into floor/ceiling cell indices and a Q0.16 weight,
  // clamping points that sit less than one cell beyond either edge.
  function automatic axis_res_t resolve_axis(input logic signed [PROD_W-1:0] prod,
                                             input int size);
    logic signed [FL_W-1:0] fl;
    logic [FRAC_W-1:0]      frac;
    logic                   frac_nz;
    logic                   fl_neg;
    logic                   ce_neg;
    logic                   fl_ge;
    logic                   ce_ge;
    axis_res_t              r;
    fl      = prod[PROD_W-1:FRAC_W];
    frac    = prod[FRAC_W-1:0];
    frac_nz = |frac;
    fl_neg  = fl[FL_W-1];
    ce_neg  = fl_neg && !((fl == -1) && frac_nz);
    fl_ge   = !fl_neg && (fl >= size);
    ce_ge   = !fl_neg && ((fl >= size) || ((fl == size - 1) && frac_nz));
    r.outside = ce_neg || fl_ge;
    if (fl_neg) begin
      r.lo = '0;
      r.hi = '0;
      r.w  = '0;
    end else if (ce_ge) begin
      r.lo = IDX_W'(size - 1);
      r.hi = IDX_W'(size - 1);
      r.w  = '0;
    end else begin
      r.lo = fl[IDX_W-1:0];
      r.hi = fl[IDX_W-1:0] + IDX_W'(frac_nz);
      r.w  = frac[FRAC_W-1:FRAC_W-W_W];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tgi_ram.sv @@
// Generic single-port RAM with registered read data.
// Stand-alone; holds the grid samples of the interpolator.
`default_nettype none

module tgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/tgi_datapath.sv @@
// Datapath: configuration registers, shared axis multiplier, grid RAM and blend pipeline.
// Depends on tgi_pkg and tgi_ram; driven by tgi_controller through ctl_cmd_t.
`default_nettype none

module tgi_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  tgi_pkg::in_item_t                in_item,
  input  tgi_pkg::ctl_cmd_t                cmd,
  output tgi_pkg::dp_status_t              status,
  output tgi_pkg::out_item_t               out_item
);

  localparam int ZP_W = tgi_pkg::SAMPLE_BITS + tgi_pkg::W_W + 2;
  localparam int YP_W = tgi_pkg::E_W + tgi_pkg::W_W + 2;

  // configuration
  logic [tgi_pkg::INV_W-1:0]          inv_x;
  logic [tgi_pkg::INV_W-1:0]          inv_y;
  logic [tgi_pkg::INV_W-1:0]          inv_z;
  logic signed [tgi_pkg::COORD_W-1:0] org_x;
  logic signed [tgi_pkg::COORD_W-1:0] org_y;
  logic signed [tgi_pkg::COORD_W-1:0] org_z;

  // query point and per-axis lookup
  logic signed [tgi_pkg::COORD_W-1:0] pt_x;
  logic signed [tgi_pkg::COORD_W-1:0] pt_y;
  logic signed [tgi_pkg::COORD_W-1:0] pt_z;
  logic signed [tgi_pkg::DIFF_W-1:0]  mul_a;
  logic signed [tgi_pkg::INV_W:0]     mul_b;
  logic signed [tgi_pkg::PROD_W-1:0]  prod;
  int                                 res_size;
  tgi_pkg::axis_res_t                 res;
  tgi_pkg::axis_res_t                 axis_x;
  tgi_pkg::axis_res_t                 axis_y;
  tgi_pkg::axis_res_t                 axis_z;
  logic                               outside;

  // grid memory
  logic [tgi_pkg::IDX_W-1:0]          ix;
  logic [tgi_pkg::IDX_W-1:0]          iy;
  logic [tgi_pkg::IDX_W-1:0]          iz;
  logic [31:0]                        rd_full;
  logic                               ram_we;
  logic [tgi_pkg::ADDR_W-1:0]         ram_addr;
  logic [tgi_pkg::SAMPLE_BITS-1:0]    ram_rdata;

  // blend pipeline
  logic                                  rd_valid;
  logic [2:0]                            rd_k;
  logic                                  rd_zero;
  logic signed [tgi_pkg::SAMPLE_BITS-1:0] sample;
  logic signed [tgi_pkg::SAMPLE_BITS-1:0] s0;
  logic signed [tgi_pkg::SAMPLE_BITS-1:0] z_base;
  logic signed [tgi_pkg::SAMPLE_BITS:0]   z_diff;
  logic signed [ZP_W-1:0]                zprod;
  logic                                  z_valid;
  logic [1:0]                            z_pair;
  logic signed [ZP_W-1:0]                e_sum;
  logic signed [tgi_pkg::E_W-1:0]        e_even;
  logic signed [tgi_pkg::E_W-1:0]        e_odd;
  logic                                  ey_valid;
  logic                                  ey_x;
  logic signed [YP_W-1:0]                yprod;
  logic signed [tgi_pkg::E_W-1:0]        y_base;
  logic                                  y_valid;
  logic                                  y_x;
  logic signed [tgi_pkg::E_W+1:0]        c_sum;
  logic signed [tgi_pkg::E_W-1:0]        c_even;
  logic signed [tgi_pkg::E_W-1:0]        c_odd;
  logic                                  cx_valid;
  logic signed [YP_W-1:0]                xprod;
  logic signed [tgi_pkg::E_W-1:0]        x_base;
  logic                                  x_valid;
  logic signed [tgi_pkg::E_W+1:0]        v_sum;
  logic signed [tgi_pkg::OUT_W-1:0]      v_sat;
  logic signed [tgi_pkg::OUT_W-1:0]      result;
  logic                                  blend_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= tgi_pkg::INV_SPACING_RESET;
      inv_y <= tgi_pkg::INV_SPACING_RESET;
      inv_z <= tgi_pkg::INV_SPACING_RESET;
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        tgi_pkg::REG_INV_SPACING_X: inv_x <= cfg_data[tgi_pkg::INV_W-1:0];
        tgi_pkg::REG_INV_SPACING_Y: inv_y <= cfg_data[tgi_pkg::INV_W-1:0];
        tgi_pkg::REG_INV_SPACING_Z: inv_z <= cfg_data[tgi_pkg::INV_W-1:0];
        tgi_pkg::REG_ORIGIN_X:      org_x <= cfg_data;
        tgi_pkg::REG_ORIGIN_Y:      org_y <= cfg_data;
        tgi_pkg::REG_ORIGIN_Z:      org_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.point_load) begin
      pt_x <= in_item.point_x;
      pt_y <= in_item.point_y;
      pt_z <= in_item.point_z;
    end
  end

  always_comb begin
    case (cmd.mul_axis)
      tgi_pkg::AXIS_X: begin
        mul_a = $signed({pt_x[tgi_pkg::COORD_W-1], pt_x})
              - $signed({org_x[tgi_pkg::COORD_W-1], org_x});
        mul_b = $signed({1'b0, inv_x});
      end
      tgi_pkg::AXIS_Y: begin
        mul_a = $signed({pt_y[tgi_pkg::COORD_W-1], pt_y})
              - $signed({org_y[tgi_pkg::COORD_W-1], org_y});
        mul_b = $signed({1'b0, inv_y});
      end
      tgi_pkg::AXIS_Z: begin
        mul_a = $signed({pt_z[tgi_pkg::COORD_W-1], pt_z})
              - $signed({org_z[tgi_pkg::COORD_W-1], org_z});
        mul_b = $signed({1'b0, inv_z});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_comb begin
    case (cmd.res_axis)
      tgi_pkg::AXIS_X: res_size = tgi_pkg::GRID_X;
      tgi_pkg::AXIS_Y: res_size = tgi_pkg::GRID_Y;
      tgi_pkg::AXIS_Z: res_size = tgi_pkg::GRID_Z;
      default:         res_size = tgi_pkg::GRID_X;
    endcase
    res = tgi_pkg::resolve_axis(prod, res_size);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      case (cmd.res_axis)
        tgi_pkg::AXIS_X: axis_x <= res;
        tgi_pkg::AXIS_Y: axis_y <= res;
        tgi_pkg::AXIS_Z: axis_z <= res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.point_load) begin
      outside <= 1'b0;
    end else if (cmd.res_en) begin
      outside <= outside | res.outside;
    end
  end

  // corner bits: [2] x high, [1] y high, [0] z high
  assign ix = cmd.corner[2] ? axis_x.hi : axis_x.lo;
  assign iy = cmd.corner[1] ? axis_y.hi : axis_y.lo;
  assign iz = cmd.corner[0] ? axis_z.hi : axis_z.lo;
  assign rd_full = (32'(ix) * 32'(tgi_pkg::GRID_Y) + 32'(iy)) * 32'(tgi_pkg::GRID_Z)
                 + 32'(iz);

  assign ram_we   = cmd.wr_en
                  && (32'(in_item.sample_index) < 32'(tgi_pkg::GRID_TOTAL))
                  && (32'(in_item.sample_index) < 32'(tgi_pkg::STORE_DEPTH));
  assign ram_addr = cmd.wr_en ? tgi_pkg::ADDR_W'(in_item.sample_index)
                              : rd_full[tgi_pkg::ADDR_W-1:0];

  tgi_ram #(
    .WIDTH (tgi_pkg::SAMPLE_BITS),
    .DEPTH (tgi_pkg::STORE_DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (tgi_pkg::SAMPLE_BITS'(in_item.sample_value)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
    end
    rd_k    <= cmd.corner;
    rd_zero <= rd_full >= 32'(tgi_pkg::STORE_DEPTH);
  end

  assign sample = rd_zero ? '0 : $signed(ram_rdata);
  assign z_diff = $signed({sample[tgi_pkg::SAMPLE_BITS-1], sample})
                - $signed({s0[tgi_pkg::SAMPLE_BITS-1], s0});

  // z blend: s0 * 1.0 + (s1 - s0) * wz, exact in Q16
  always_ff @(posedge clk) begin
    if (rst) begin
      z_valid <= 1'b0;
    end else begin
      z_valid <= rd_valid && rd_k[0];
    end
    if (rd_valid && !rd_k[0]) begin
      s0 <= sample;
    end
    if (rd_valid && rd_k[0]) begin
      zprod  <= z_diff * $signed({1'b0, axis_z.w});
      z_base <= s0;
      z_pair <= rd_k[2:1];
    end
  end

  assign e_sum = $signed({{2{z_base[tgi_pkg::SAMPLE_BITS-1]}}, z_base, {tgi_pkg::W_W{1'b0}}})
               + zprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ey_valid <= 1'b0;
    end else begin
      ey_valid <= z_valid && z_pair[0];
    end
    if (z_valid) begin
      if (z_pair[0]) begin
        e_odd <= e_sum[tgi_pkg::E_W-1:0];
      end else begin
        e_even <= e_sum[tgi_pkg::E_W-1:0];
      end
    end
    ey_x <= z_pair[1];
  end

  // y blend, floor back to Q16
  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else begin
      y_valid <= ey_valid;
    end
    if (ey_valid) begin
      yprod  <= ($signed({e_odd[tgi_pkg::E_W-1], e_odd})
               - $signed({e_even[tgi_pkg::E_W-1], e_even})) * $signed({1'b0, axis_y.w});
      y_base <= e_even;
      y_x    <= ey_x;
    end
  end

  assign c_sum = $signed({{2{y_base[tgi_pkg::E_W-1]}}, y_base})
               + yprod[YP_W-1:tgi_pkg::W_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cx_valid <= 1'b0;
    end else begin
      cx_valid <= y_valid && y_x;
    end
    if (y_valid) begin
      if (y_x) begin
        c_odd <= c_sum[tgi_pkg::E_W-1:0];
      end else begin
        c_even <= c_sum[tgi_pkg::E_W-1:0];
      end
    end
  end

  // x blend
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else begin
      x_valid <= cx_valid;
    end
    if (cx_valid) begin
      xprod  <= ($signed({c_odd[tgi_pkg::E_W-1], c_odd})
               - $signed({c_even[tgi_pkg::E_W-1], c_even})) * $signed({1'b0, axis_x.w});
      x_base <= c_even;
    end
  end

  assign v_sum = $signed({{2{x_base[tgi_pkg::E_W-1]}}, x_base})
               + xprod[YP_W-1:tgi_pkg::W_W];

  always_comb begin
    if ((&v_sum[tgi_pkg::E_W+1:tgi_pkg::OUT_W-1]) || !(|v_sum[tgi_pkg::E_W+1:tgi_pkg::OUT_W-1]))
    begin
      v_sat = v_sum[tgi_pkg::OUT_W-1:0];
    end else if (v_sum[tgi_pkg::E_W+1]) begin
      v_sat = {1'b1, {(tgi_pkg::OUT_W-1){1'b0}}};
    end else begin
      v_sat = {1'b0, {(tgi_pkg::OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_done <= 1'b0;
    end else begin
      blend_done <= x_valid;
    end
    if (x_valid) begin
      result <= v_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (outside) begin
        out_item.interpolated_value <= '0;
        out_item.outside_grid       <= 1'b1;
      end else begin
        out_item.interpolated_value <= result;
        out_item.outside_grid       <= 1'b0;
      end
    end
  end

  assign status.outside    = outside;
  assign status.blend_done = blend_done;

endmodule

`default_nettype wire

@@ hdl/tgi_controller.sv @@
// Sequencer for the interpolator: walks a query through lookup, corner reads and output.
// Depends on tgi_pkg; commands tgi_datapath through ctl_cmd_t.
`default_nettype none

module tgi_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  tgi_pkg::dp_status_t status,
  output tgi_pkg::ctl_cmd_t   cmd
);

  tgi_pkg::ctl_state_t state;
  tgi_pkg::ctl_state_t state_next;
  logic [2:0]          cnt;
  logic [2:0]          cnt_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tgi_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tgi_pkg::ST_IDLE: begin
        if (in_valid && (in_command == tgi_pkg::CMD_QUERY)) begin
          state_next = tgi_pkg::ST_MUL_X;
        end
      end
      tgi_pkg::ST_MUL_X: state_next = tgi_pkg::ST_MUL_Y;
      tgi_pkg::ST_MUL_Y: state_next = tgi_pkg::ST_MUL_Z;
      tgi_pkg::ST_MUL_Z: state_next = tgi_pkg::ST_RES_Z;
      tgi_pkg::ST_RES_Z: state_next = tgi_pkg::ST_CHECK;
      tgi_pkg::ST_CHECK: begin
        state_next = status.outside ? tgi_pkg::ST_DONE : tgi_pkg::ST_FETCH;
      end
      tgi_pkg::ST_FETCH: begin
        if (cnt == 3'd7) begin
          state_next = tgi_pkg::ST_BLEND;
        end
      end
      tgi_pkg::ST_BLEND: begin
        if (status.blend_done) begin
          state_next = tgi_pkg::ST_DONE;
        end
      end
      tgi_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = tgi_pkg::ST_IDLE;
        end
      end
      default: state_next = tgi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.wr_en      = 1'b0;
    cmd.point_load = 1'b0;
    cmd.mul_en     = 1'b0;
    cmd.mul_axis   = tgi_pkg::AXIS_X;
    cmd.res_en     = 1'b0;
    cmd.res_axis   = tgi_pkg::AXIS_X;
    cmd.rd_en      = 1'b0;
    cmd.corner     = cnt;
    cmd.out_load   = 1'b0;
    case (state)
      tgi_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.wr_en      = in_valid && (in_command == tgi_pkg::CMD_WRITE);
        cmd.point_load = in_valid && (in_command == tgi_pkg::CMD_QUERY);
      end
      tgi_pkg::ST_MUL_X: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = tgi_pkg::AXIS_X;
      end
      tgi_pkg::ST_MUL_Y: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = tgi_pkg::AXIS_Y;
        cmd.res_en   = 1'b1;
        cmd.res_axis = tgi_pkg::AXIS_X;
      end
      tgi_pkg::ST_MUL_Z: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = tgi_pkg::AXIS_Z;
        cmd.res_en   = 1'b1;
        cmd.res_axis = tgi_pkg::AXIS_Y;
      end
      tgi_pkg::ST_RES_Z: begin
        cmd.res_en   = 1'b1;
        cmd.res_axis = tgi_pkg::AXIS_Z;
      end
      tgi_pkg::ST_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      tgi_pkg::ST_DONE: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign cnt_next = (state == tgi_pkg::ST_FETCH) ? cnt + 3'd1 : 3'd0;

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

@@ hdl/trilinear_grid_interpolator.sv @@
// Top level of the trilinear grid interpolator: ports, controller and datapath.
// Depends on tgi_pkg, tgi_controller, tgi_datapath (which holds tgi_ram).
//
// Holds a 32x32x32 grid of signed 16-bit samples in one single-port RAM and answers
// Q16.16 query points by trilinear interpolation. A write item (command 0) stores one
// sample and gives no result. A query item (command 1) gives one result: the interpolated
// value when the point is inside the grid, zero with the flag set when it lies one cell
// or more outside. A query runs through the shared axis multiplier (once per axis), the
// eight corner reads through the one RAM port and the blend pipeline behind them; an
// outside point skips reads and blend. No item is taken until the query ends. A result
// waiting in the output register does not stop the next item being taken. Configuration
// writes are always accepted and must only be made while the block is idle; grid
// entries must be written before any query reads them.
`default_nettype none

module trilinear_grid_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tgi_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tgi_pkg::out_item_t               out_item
);

  tgi_pkg::ctl_cmd_t   cmd;
  tgi_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tgi_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_item.command),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .cmd        (cmd)
  );

  tgi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ tb/trilinear_grid_interpolator_checker.sv @@
`timescale 1ns / 1ps
// Checker for trilinear_grid_interpolator: watches the config, item and result channels,
// keeps its own copy of the grid and registers, predicts each query and compares.
// Depends on tgi_pkg.
module trilinear_grid_interpolator_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  tgi_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  tgi_pkg::out_item_t             out_item,
  output int                             mismatches,
  output int                             outstanding
);
  import tgi_pkg::*;

  typedef struct packed {
    int lo;
    int hi;
    int wt;
    bit beyond;
  } cell_span_t;

  logic signed [SAMPLE_BITS-1:0] grid_store [STORE_DEPTH];
  logic [INV_W-1:0]              inv_x, inv_y, inv_z;
  logic signed [COORD_W-1:0]     origin_x, origin_y, origin_z;
  out_item_t                     expected_results [$];

  // Q32 grid coordinate -> floor/ceiling cells and Q0.16 weight, clamped at the edges
  function automatic cell_span_t locate(input logic signed [COORD_W-1:0] pos, org,
                                        input logic [INV_W-1:0] inv, input int size);
    longint     u, fl, ce;
    cell_span_t s;
    u  = (longint'(pos) - longint'(org)) * longint'(inv);
    fl = u >>> 32;
    ce = fl + ((u[31:0] != 0) ? 1 : 0);
    s.beyond = (ce < 0) || (fl >= size);
    s.lo = int'(fl);
    s.hi = int'(ce);
    s.wt = int'(u[31:16]);
    if (fl < 0) begin
      s.lo = 0;
      s.hi = 0;
      s.wt = 0;
    end else if (ce >= size) begin
      s.lo = size - 1;
      s.hi = size - 1;
      s.wt = 0;
    end
    return s;
  endfunction

  function automatic longint along_z(input int ix, input int iy, input cell_span_t sz);
    longint s0, s1;
    s0 = longint'(grid_store[(ix * GRID_Y + iy) * GRID_Z + sz.lo]);
    s1 = longint'(grid_store[(ix * GRID_Y + iy) * GRID_Z + sz.hi]);
    return s0 * (65536 - sz.wt) + s1 * sz.wt;
  endfunction

  // weighted mix of two Q16 values, floored back to Q16
  function automatic longint mix(input longint a, input longint b, input int wt);
    return (a * (65536 - wt) + b * wt) >>> 16;
  endfunction

  function automatic out_item_t interpolate(input in_item_t q);
    cell_span_t sx, sy, sz;
    longint     c0, c1, v;
    out_item_t  r;
    sx = locate(q.point_x, origin_x, inv_x, GRID_X);
    sy = locate(q.point_y, origin_y, inv_y, GRID_Y);
    sz = locate(q.point_z, origin_z, inv_z, GRID_Z);
    r.interpolated_value = '0;
    r.outside_grid       = 1'b1;
    if (sx.beyond || sy.beyond || sz.beyond) return r;
    c0 = mix(along_z(sx.lo, sy.lo, sz), along_z(sx.lo, sy.hi, sz), sy.wt);
    c1 = mix(along_z(sx.hi, sy.lo, sz), along_z(sx.hi, sy.hi, sz), sy.wt);
    v  = mix(c0, c1, sx.wt);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    else if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.interpolated_value = v[31:0];
    r.outside_grid       = 1'b0;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      inv_x    = INV_SPACING_RESET;
      inv_y    = INV_SPACING_RESET;
      inv_z    = INV_SPACING_RESET;
      origin_x = '0;
      origin_y = '0;
      origin_z = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result transfer with nothing outstanding (value %0d)",
                                  out_item.interpolated_value));
        end else begin
          want = expected_results.pop_front();
          if (out_item.interpolated_value !== want.interpolated_value)
            flag_mismatch($sformatf("interpolated_value expected %0d, got %0d",
                                    want.interpolated_value, out_item.interpolated_value));
          if (out_item.outside_grid !== want.outside_grid)
            flag_mismatch($sformatf("outside_grid expected %0b, got %0b",
                                    want.outside_grid, out_item.outside_grid));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INV_SPACING_X: inv_x = cfg_data[INV_W-1:0];
          REG_INV_SPACING_Y: inv_y = cfg_data[INV_W-1:0];
          REG_INV_SPACING_Z: inv_z = cfg_data[INV_W-1:0];
          REG_ORIGIN_X:      origin_x = cfg_data;
          REG_ORIGIN_Y:      origin_y = cfg_data;
          REG_ORIGIN_Z:      origin_z = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_item.command == CMD_WRITE) begin
          if (int'(in_item.sample_index) < GRID_TOTAL)
            grid_store[in_item.sample_index] = in_item.sample_value;
        end else begin
          expected_results.push_back(interpolate(in_item));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ tb/trilinear_grid_interpolator_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for trilinear_grid_interpolator: clock, reset, stimulus, sink and verdict.
// Depends on tgi_pkg, the RTL under hdl and trilinear_grid_interpolator_checker.
module trilinear_grid_interpolator_tb;
  import tgi_pkg::*;

  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;

  int  mismatches;
  int  outstanding;
  int  quiet_cycles;
  int  items_sent;
  bit  sender_calm;
  bit  sample_written [GRID_TOTAL];

  logic [INV_W-1:0]          shadow_inv [3];
  logic signed [COORD_W-1:0] shadow_origin [3];

  always #2 clk = ~clk;

  trilinear_grid_interpolator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  trilinear_grid_interpolator_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Cells a query touches on one axis; returns 1 when the point is off the grid.
  function automatic bit corner_range(input logic signed [COORD_W-1:0] pos, org,
                                      input logic [INV_W-1:0] inv, input int size,
                                      output int lo, output int hi);
    longint u, fl, ce;
    u  = (longint'(pos) - longint'(org)) * longint'(inv);
    fl = u >>> 32;
    ce = fl + ((u[31:0] != 0) ? 1 : 0);
    lo = (fl < 0) ? 0 : (ce >= size) ? size - 1 : int'(fl);
    hi = (fl < 0) ? 0 : (ce >= size) ? size - 1 : int'(ce);
    return (ce < 0) || (fl >= size);
  endfunction

  // Point aimed at grid coordinate -2 .. size+1 under the current axis setting
  function automatic logic signed [COORD_W-1:0] aim(input logic signed [COORD_W-1:0] org,
                                                    input logic [INV_W-1:0] inv,
                                                    input int size);
    longint cell_q16, span, pos;
    if (inv == '0) return $urandom;
    cell_q16 = longint'($urandom_range(0, (size + 3) * 65536)) - 2 * 65536;
    if ($urandom_range(0, 3) == 0) cell_q16 = cell_q16 & ~longint'(16'hFFFF);
    span = (cell_q16 <<< 16) / longint'(inv);
    if ($urandom_range(0, 1) == 1) span = span + longint'($urandom_range(0, 8)) - 4;
    pos = longint'(org) + span;
    if (pos > 64'sd2147483647) pos = 64'sd2147483647;
    else if (pos < -64'sd2147483648) pos = -64'sd2147483648;
    return pos[31:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] moderate_inv();
    return {8'($urandom), 24'($urandom_range(32'h0000_2000, 32'h0008_0000))};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] near_origin();
    return 32'(int'($urandom_range(0, 96 * 65536)) - 48 * 65536);
  endfunction

  // Entered and left at a falling edge; valid stays up across back-to-back transfers.
  task automatic push_item(input in_item_t req);
    int gap;
    if (items_sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.command == CMD_WRITE) sample_written[req.sample_index] = 1'b1;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_sample(input int addr, input logic [15:0] value);
    in_item_t req;
    req.command      = CMD_WRITE;
    req.sample_index = addr[14:0];
    req.sample_value = value;
    req.point_x      = $urandom;
    req.point_y      = $urandom;
    req.point_z      = $urandom;
    push_item(req);
  endtask

  // Corners not yet loaded are written first, so no query reads an empty entry.
  task automatic query_point(input logic signed [COORD_W-1:0] px, py, pz);
    int       xl, xh, yl, yh, zl, zh, addr;
    bit       beyond;
    in_item_t req;
    beyond = corner_range(px, shadow_origin[0], shadow_inv[0], GRID_X, xl, xh);
    beyond = corner_range(py, shadow_origin[1], shadow_inv[1], GRID_Y, yl, yh) || beyond;
    beyond = corner_range(pz, shadow_origin[2], shadow_inv[2], GRID_Z, zl, zh) || beyond;
    if (!beyond) begin
      for (int c = 0; c < 8; c++) begin
        addr = ((c[2] ? xh : xl) * GRID_Y + (c[1] ? yh : yl)) * GRID_Z + (c[0] ? zh : zl);
        if (!sample_written[addr]) put_sample(addr, 16'($urandom));
      end
    end
    req.command      = CMD_QUERY;
    req.sample_index = 15'($urandom);
    req.sample_value = 16'($urandom);
    req.point_x      = px;
    req.point_y      = py;
    req.point_z      = pz;
    push_item(req);
  endtask

  task automatic run_random(input int budget);
    int stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        put_sample($urandom_range(0, GRID_TOTAL - 1), 16'($urandom));
      else if (pick < 27)
        query_point($urandom, $urandom, $urandom);
      else
        query_point(aim(shadow_origin[0], shadow_inv[0], GRID_X),
                    aim(shadow_origin[1], shadow_inv[1], GRID_Y),
                    aim(shadow_origin[2], shadow_inv[2], GRID_Z));
    end
  endtask

  // Drop valid, wait for every result, then give a write still in flight time to land.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INV_SPACING_X: shadow_inv[0] = data[INV_W-1:0];
      REG_INV_SPACING_Y: shadow_inv[1] = data[INV_W-1:0];
      REG_INV_SPACING_Z: shadow_inv[2] = data[INV_W-1:0];
      REG_ORIGIN_X:      shadow_origin[0] = data;
      REG_ORIGIN_Y:      shadow_origin[1] = data;
      REG_ORIGIN_Z:      shadow_origin[2] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_axes(input logic [CFG_DATA_W-1:0] ix, iy, iz, ox, oy, oz,
                              input bit spare);
    write_reg(REG_INV_SPACING_X, ix);
    write_reg(REG_INV_SPACING_Y, iy);
    write_reg(REG_INV_SPACING_Z, iz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    if (spare) begin
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    items_sent  = 0;
    sender_calm = 1'b0;
    for (int a = 0; a < 3; a++) begin
      shadow_inv[a]    = INV_SPACING_RESET;
      shadow_origin[a] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: unit spacing, origin at zero, so the integer part is the cell
    put_sample(0, 16'h8000);
    put_sample(GRID_TOTAL - 1, 16'h7FFF);
    query_point('0, '0, '0);
    query_point((GRID_X - 1) * Q_ONE, (GRID_Y - 1) * Q_ONE, (GRID_Z - 1) * Q_ONE);
    query_point(-Q_HALF, -Q_HALF, -Q_HALF);
    query_point((GRID_X - 1) * Q_ONE + Q_HALF, (GRID_Y - 1) * Q_ONE + Q_HALF,
                (GRID_Z - 1) * Q_ONE + Q_HALF);
    query_point(-Q_ONE, '0, '0);
    query_point('0, '0, GRID_Z * Q_ONE);
    query_point(COORD_MAX, COORD_MIN, '0);
    query_point(Q_HALF, Q_HALF, Q_HALF);
    query_point(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF);
    query_point(Q_ONE, 32'sh0000_0001, Q_HALF);

    run_random(170);
    settle();
    program_axes(moderate_inv(), moderate_inv(), moderate_inv(),
                 near_origin(), near_origin(), near_origin(), 1'b0);
    run_random(220);
    settle();
    // extremes: finest and coarsest spacing, origin at both ends of the range
    program_axes(32'h0000_0001, 32'h00FF_FFFF, 32'hFFFF_FFFF, COORD_MIN, COORD_MAX, '0, 1'b0);
    run_random(200);
    settle();
    // zero z inverse spacing (upper byte ignored) and writes to unused indexes
    program_axes(moderate_inv(), 32'h5AFF_FFFF, 32'hFF00_0000, $urandom, $urandom, $urandom,
                 1'b1);
    run_random(200);
    settle();
    program_axes({8'h00, INV_SPACING_RESET}, {8'h00, INV_SPACING_RESET},
                 {8'h00, INV_SPACING_RESET}, near_origin(), near_origin(), near_origin(), 1'b0);
    run_random(230);
    settle();

    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Result sink: random stalls, calm stretches, and two long hold-offs so the block backs up.
  initial begin
    int gap, taken;
    bit calm;
    taken     = 0;
    calm      = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 60 || taken == 150) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // no transfer on any channel for too long: give up
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
